>>> sv/dfr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the fixed frame sum deframer.
// No dependencies; imported by every module of the block.
package dfr_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int OVERHEAD    = 3;
    localparam int MAX_FRAME   = MAX_PAYLOAD + OVERHEAD;

    // window ring: power of two, room for at least two frames of the maximum length
    localparam int RING_AW    = $clog2(2 * MAX_FRAME);
    localparam int RING_DEPTH = 1 << RING_AW;

    localparam int RX_DEPTH = 4;
    localparam int RX_AW    = $clog2(RX_DEPTH);
    localparam int RX_CW    = $clog2(RX_DEPTH + 1);
    localparam int TX_DEPTH = 4;
    localparam int TX_AW    = $clog2(TX_DEPTH);
    localparam int TX_CW    = $clog2(TX_DEPTH + 1);

    localparam logic [7:0] HDR_BYTE = 8'hAA;
    localparam logic [7:0] FTR_BYTE = 8'h55;

    localparam logic [5:0] PLEN_RESET  = 6'd8;
    localparam logic [7:0] LIMIT_RESET = 8'd16;

    localparam logic REG_PAYLOAD_LENGTH = 1'b0;
    localparam logic REG_ERROR_LIMIT    = 1'b1;

    typedef struct packed {
        logic [5:0] plen;   // effective payload length, 1..MAX_PAYLOAD
        logic [5:0] flen;   // plen + overhead
        logic [7:0] limit;  // effective error limit, never zero
        logic       flush;  // payload length being written this cycle
    } t_cfg;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [4:0]  byte_index;
        logic        last_byte;
        logic [31:0] good_frames;
        logic [31:0] checksum_failures;
    } t_result;

endpackage

>>> sv/dfr_rx_queue.sv
`timescale 1ns / 1ps
// Front end: short byte queue that takes received bytes from the input side.
// Depends on dfr_pkg.
module dfr_rx_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_data,
    output logic       o_full,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_data
);
    import dfr_pkg::*;

    logic [7:0]       r_mem [RX_DEPTH];
    logic [RX_AW-1:0] r_wr_ptr;
    logic [RX_AW-1:0] r_rd_ptr;
    logic [RX_CW-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == RX_CW'(RX_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + RX_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + RX_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + RX_CW'(1);
                2'b01:   r_count <= r_count - RX_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> sv/dfr_tx_queue.sv
`timescale 1ns / 1ps
// Result queue: holds payload results until the sink pops them.
// Depends on dfr_pkg (t_result, depth constants).
module dfr_tx_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  dfr_pkg::t_result        i_data,
    output logic [dfr_pkg::TX_CW-1:0] o_count,
    input  logic                    i_pop,
    output logic                    o_empty,
    output dfr_pkg::t_result        o_data
);
    import dfr_pkg::*;

    t_result          r_mem [TX_DEPTH];
    logic [TX_AW-1:0] r_wr_ptr;
    logic [TX_AW-1:0] r_rd_ptr;
    logic [TX_CW-1:0] r_count;
    logic             do_pop;

    // engine only pushes when it has reserved room, so no full check here
    assign o_count = r_count;
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + TX_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + TX_AW'(1);
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + TX_CW'(1);
                2'b01:   r_count <= r_count - TX_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> sv/dfr_engine.sv
`timescale 1ns / 1ps
// Back end: window ring memory, frame check, error counting and payload readout.
// Depends on dfr_pkg.
module dfr_engine (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dfr_pkg::t_cfg             i_cfg,
    input  logic                      i_rx_empty,
    input  logic [7:0]                i_rx_byte,
    output logic                      o_rx_pop,
    input  logic [dfr_pkg::TX_CW-1:0] i_tx_count,
    output logic                      o_tx_push,
    output dfr_pkg::t_result          o_tx_data
);
    import dfr_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_HEAD, S_EMIT} t_state;

    t_state             r_state;
    logic [7:0]         r_mem [RING_DEPTH];
    logic [7:0]         r_rd_data;
    logic [RING_AW-1:0] r_head;      // ring address of oldest window byte
    logic [5:0]         r_fill;
    logic [7:0]         r_sum;       // wrapping sum of all window bytes
    logic [7:0]         r_hbyte;     // copy of oldest window byte
    logic [7:0]         r_prev;      // newest window byte
    logic [7:0]         r_cons;
    logic [31:0]        r_frames;
    logic [31:0]        r_ckerr;
    logic [RING_AW-1:0] r_emit_ptr;
    logic [4:0]         r_idx;
    logic               r_rv;        // read data is a payload byte for the result queue
    logic [4:0]         r_rv_idx;
    logic               r_rv_last;

    logic               rx_take;
    logic [5:0]         n_fill;
    logic               at_full;
    logic [7:0]         pay_sum;
    logic               hdr_ok;
    logic               ftr_ok;
    logic               frame_ok;
    logic [7:0]         n_cons;
    logic               cons_hit;
    logic               emit_go;
    logic               emit_last;
    logic               rd_en;
    logic [RING_AW-1:0] rd_addr;
    logic [RING_AW-1:0] wr_addr;

    assign rx_take  = (r_state == S_IDLE) && !i_rx_empty;
    assign o_rx_pop = rx_take;
    assign n_fill   = r_fill + 6'd1;
    assign at_full  = (n_fill == i_cfg.flen);
    // payload sum = window total less header, checksum and footer (footer not yet in r_sum)
    assign pay_sum  = r_sum - r_hbyte - r_prev;
    assign hdr_ok   = (r_hbyte == HDR_BYTE);
    assign ftr_ok   = (i_rx_byte == FTR_BYTE);
    assign frame_ok = hdr_ok && ftr_ok && (pay_sum == r_prev);
    assign n_cons   = r_cons + 8'd1;
    assign cons_hit = (n_cons >= i_cfg.limit);

    assign emit_go   = (r_state == S_EMIT) &&
                       ((i_tx_count + TX_CW'(r_rv)) < TX_CW'(TX_DEPTH));
    assign emit_last = ({1'b0, r_idx} == (i_cfg.plen - 6'd1));
    assign rd_en     = emit_go || (rx_take && at_full && !frame_ok && !cons_hit);
    assign rd_addr   = (r_state == S_EMIT) ? r_emit_ptr : r_head + RING_AW'(1);
    assign wr_addr   = r_head + RING_AW'(r_fill);

    assign o_tx_push = r_rv;
    assign o_tx_data = '{payload_byte:      r_rd_data,
                         byte_index:        r_rv_idx,
                         last_byte:         r_rv_last,
                         good_frames:       r_frames,
                         checksum_failures: r_ckerr};

    always_ff @(posedge i_clk) begin
        if (rx_take) begin
            r_mem[wr_addr] <= i_rx_byte;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_fill     <= '0;
            r_sum      <= '0;
            r_hbyte    <= '0;
            r_prev     <= '0;
            r_cons     <= '0;
            r_frames   <= '0;
            r_ckerr    <= '0;
            r_emit_ptr <= '0;
            r_idx      <= '0;
            r_rv       <= 1'b0;
            r_rv_idx   <= '0;
            r_rv_last  <= 1'b0;
        end else begin
            r_rv <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (rx_take) begin
                        r_prev <= i_rx_byte;
                        if (!at_full) begin
                            r_fill <= n_fill;
                            if (r_fill == 6'd0) begin
                                r_sum   <= i_rx_byte;
                                r_hbyte <= i_rx_byte;
                            end else begin
                                r_sum <= r_sum + i_rx_byte;
                            end
                        end else if (frame_ok) begin
                            r_cons     <= '0;
                            r_frames   <= r_frames + 32'd1;
                            r_fill     <= '0;
                            r_emit_ptr <= r_head + RING_AW'(1);
                            r_head     <= r_head + RING_AW'(i_cfg.flen);
                            r_idx      <= '0;
                            r_state    <= S_EMIT;
                        end else begin
                            if (hdr_ok && ftr_ok) begin
                                r_ckerr <= r_ckerr + 32'd1;
                            end
                            r_head <= r_head + RING_AW'(1);
                            if (cons_hit) begin
                                // too many misses in a row: drop the whole window
                                r_cons <= '0;
                                r_fill <= '0;
                            end else begin
                                r_cons  <= n_cons;
                                r_fill  <= i_cfg.flen - 6'd1;
                                r_sum   <= r_sum + i_rx_byte - r_hbyte;
                                r_state <= S_HEAD;
                            end
                        end
                    end
                end
                S_HEAD: begin
                    r_hbyte <= r_rd_data;
                    r_state <= S_IDLE;
                end
                S_EMIT: begin
                    if (emit_go) begin
                        r_rv       <= 1'b1;
                        r_rv_idx   <= r_idx;
                        r_rv_last  <= emit_last;
                        r_idx      <= r_idx + 5'd1;
                        r_emit_ptr <= r_emit_ptr + RING_AW'(1);
                        if (emit_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (i_cfg.flush) begin
                r_fill <= '0;
            end
        end
    end

`ifndef SYNTHESIS
    a_fill_below_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_fill < i_cfg.flen))
        else $error("window fill reached frame length while idle");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rv |-> (i_tx_count < TX_CW'(TX_DEPTH)))
        else $error("payload byte pushed into a full result queue");

    a_head_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HEAD) |=> (r_state == S_IDLE))
        else $error("header reload took more than one cycle");

    a_emit_counts_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && rx_take && at_full && frame_ok)
            |=> (r_state == S_EMIT && r_frames == $past(r_frames) + 32'd1))
        else $error("good frame did not start readout with frame count bumped");
`endif

endmodule

>>> sv/fixed_frame_sum_deframer.sv
`timescale 1ns / 1ps
// A byte is checked against the window when the engine, in S_IDLE, takes it from the
// receive queue; a failed check that slides the window goes through S_HEAD to reload the
// header byte. The first payload result of a good frame is visible once it has passed the
// receive queue, S_EMIT, the registered ring read and the result queue, then one per cycle
// while the sink pops. The engine takes 1 byte per cycle in S_IDLE and none during a readout.
// Synchronous active-low reset: window, counters and queues empty, payload_length 8, error_limit 16.
module fixed_frame_sum_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_payload_byte,
    output logic [4:0]  o_byte_index,
    output logic        o_last_byte,
    output logic [31:0] o_good_frames,
    output logic [31:0] o_checksum_failures,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);
    import dfr_pkg::*;

    logic [5:0]       r_plen;
    logic [7:0]       r_limit;
    t_cfg             cfg;
    logic [5:0]       eff_plen;
    logic             rx_empty;
    logic [7:0]       rx_byte;
    logic             rx_pop;
    logic [TX_CW-1:0] tx_count;
    logic             tx_push;
    t_result          tx_in;
    t_result          tx_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen  <= PLEN_RESET;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PAYLOAD_LENGTH: r_plen  <= i_cfg_data[5:0];
                REG_ERROR_LIMIT:    r_limit <= i_cfg_data;
                default:            r_plen  <= r_plen;
            endcase
        end
    end

    // zero length acts as one, anything above the maximum is clamped
    always_comb begin
        eff_plen = r_plen;
        if (r_plen == 6'd0) begin
            eff_plen = 6'd1;
        end else if (r_plen > 6'(MAX_PAYLOAD)) begin
            eff_plen = 6'(MAX_PAYLOAD);
        end
    end

    assign cfg.plen  = eff_plen;
    assign cfg.flen  = eff_plen + 6'(OVERHEAD);
    assign cfg.limit = (r_limit == 8'd0) ? 8'd1 : r_limit;
    assign cfg.flush = i_cfg_we && (i_cfg_idx == REG_PAYLOAD_LENGTH);

    dfr_rx_queue u_rx_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (i_rx_byte),
        .o_full  (full),
        .i_pop   (rx_pop),
        .o_empty (rx_empty),
        .o_data  (rx_byte)
    );

    dfr_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_rx_empty (rx_empty),
        .i_rx_byte  (rx_byte),
        .o_rx_pop   (rx_pop),
        .i_tx_count (tx_count),
        .o_tx_push  (tx_push),
        .o_tx_data  (tx_in)
    );

    dfr_tx_queue u_tx_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (tx_push),
        .i_data  (tx_in),
        .o_count (tx_count),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (tx_out)
    );

    assign o_payload_byte      = tx_out.payload_byte;
    assign o_byte_index        = tx_out.byte_index;
    assign o_last_byte         = tx_out.last_byte;
    assign o_good_frames       = tx_out.good_frames;
    assign o_checksum_failures = tx_out.checksum_failures;

endmodule

>>> tb/fixed_frame_sum_deframer_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for fixed_frame_sum_deframer: random and hand-built frames in,
// payload transfers checked against a scoreboard that tracks the byte window.
// Depends on dfr_pkg and the deframer RTL only.
module fixed_frame_sum_deframer_tb;
    import dfr_pkg::*;

    localparam int LIMIT_CYCLES  = 100_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int REPORT_MAX    = 10;

    typedef enum int {FLAW_NONE, FLAW_CHECKSUM, FLAW_HEADER, FLAW_FOOTER, FLAW_TRUNCATED}
        t_flaw;

    class frame_scoreboard;
        logic [7:0]  window [MAX_FRAME];
        int unsigned fill;
        logic [7:0]  run_errors;
        logic [31:0] frames_ok;
        logic [31:0] sum_failures;
        logic [5:0]  plen_reg;
        logic [7:0]  limit_reg;
        t_result     expected_q [$];
        int unsigned mismatches;
        int unsigned bytes_in;
        int unsigned results_seen;

        function new();
            fill         = 0;
            run_errors   = '0;
            frames_ok    = '0;
            sum_failures = '0;
            plen_reg     = PLEN_RESET;
            limit_reg    = LIMIT_RESET;
            mismatches   = 0;
            bytes_in     = 0;
            results_seen = 0;
        endfunction

        function int unsigned eff_plen();
            if (plen_reg == 0)
                return 1;
            if (plen_reg > MAX_PAYLOAD)
                return MAX_PAYLOAD;
            return plen_reg;
        endfunction

        function void write_reg(input logic idx, input logic [7:0] val);
            if (idx == REG_PAYLOAD_LENGTH) begin
                plen_reg = val[5:0];
                fill     = 0;   // old-length bytes are dropped
            end else begin
                limit_reg = val;
            end
        endfunction

        function void note_rx(input logic [7:0] b);
            int unsigned plen;
            int unsigned flen;
            int unsigned lim;
            int unsigned i;
            logic [7:0]  sum;
            t_result     r;
            plen = eff_plen();
            flen = plen + OVERHEAD;
            bytes_in++;
            if (fill < flen) begin
                window[fill] = b;
                fill++;
            end
            if (fill < flen)
                return;
            if (window[0] == HDR_BYTE && window[flen - 1] == FTR_BYTE) begin
                sum = '0;
                for (i = 0; i < plen; i++)
                    sum += window[1 + i];
                if (sum == window[flen - 2]) begin
                    run_errors = '0;
                    frames_ok++;
                    for (i = 0; i < plen; i++) begin
                        r.payload_byte      = window[1 + i];
                        r.byte_index        = 5'(i);
                        r.last_byte         = (i + 1 == plen);
                        r.good_frames       = frames_ok;
                        r.checksum_failures = sum_failures;
                        expected_q.push_back(r);
                    end
                    fill = 0;
                    return;
                end
                // header and footer fine, so this one counts as a checksum failure
                sum_failures++;
            end
            for (i = 0; i + 1 < flen; i++)
                window[i] = window[i + 1];
            fill = flen - 1;
            run_errors++;
            lim = (limit_reg == 0) ? 1 : limit_reg;
            if (run_errors >= lim) begin
                run_errors = '0;
                fill       = 0;
            end
        endfunction

        function void check_result(input t_result got);
            t_result exp;
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("[%0t] unexpected transfer: byte %02h idx %0d last %0b", $realtime,
                             got.payload_byte, got.byte_index, got.last_byte);
                return;
            end
            exp = expected_q.pop_front();
            if (got.payload_byte !== exp.payload_byte || got.byte_index !== exp.byte_index ||
                got.last_byte !== exp.last_byte || got.good_frames !== exp.good_frames ||
                got.checksum_failures !== exp.checksum_failures) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("[%0t] mismatch: exp byte %02h idx %0d last %0b good %0d cksum %0d",
                             $realtime, exp.payload_byte, exp.byte_index, exp.last_byte,
                             exp.good_frames, exp.checksum_failures);
                    $display("            got byte %02h idx %0d last %0b good %0d cksum %0d",
                             got.payload_byte, got.byte_index, got.last_byte,
                             got.good_frames, got.checksum_failures);
                end
            end
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        push       = 1'b0;
    logic [7:0]  i_rx_byte  = '0;
    logic        pop        = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic        i_cfg_idx  = REG_PAYLOAD_LENGTH;
    logic [7:0]  i_cfg_data = '0;
    logic        full;
    logic        empty;
    logic [7:0]  o_payload_byte;
    logic [4:0]  o_byte_index;
    logic        o_last_byte;
    logic [31:0] o_good_frames;
    logic [31:0] o_checksum_failures;

    frame_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req      = 0;
    int cycle_count   = 0;
    int settings_run  = 0;

    fixed_frame_sum_deframer dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_rx_byte           (i_rx_byte),
        .empty               (empty),
        .pop                 (pop),
        .o_payload_byte      (o_payload_byte),
        .o_byte_index        (o_byte_index),
        .o_last_byte         (o_last_byte),
        .o_good_frames       (o_good_frames),
        .o_checksum_failures (o_checksum_failures),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (push && !full)
            sb.note_rx(i_rx_byte);
        if (pop && !empty)
            sb.check_result(t_result'({o_payload_byte, o_byte_index, o_last_byte,
                                       o_good_frames, o_checksum_failures}));
    end

    // receiver: random stalls, plus a long hold-off on request
    always begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timed out after %0d cycles, %0d transfers outstanding",
                 cycle_count, sb.expected_q.size());
        $display("end of test: mismatches");
        $finish;
    end

    // caller sits at a falling edge; returns at the falling edge after the transfer
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push      <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    // the wait with the write strobe low after the write keeps back-to-back writes apart
    task automatic write_reg(input logic idx, input logic [7:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, val);
        @(negedge i_clk);
    endtask

    // drain outstanding payload, then let unproductive bytes clear the pipe
    task automatic settle();
        push <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_frame(input t_flaw flaw);
        int unsigned plen;
        int unsigned cut;
        int unsigned i;
        logic [7:0]  body [MAX_PAYLOAD];
        logic [7:0]  sum;
        logic [7:0]  b;
        plen = sb.eff_plen();
        sum  = '0;
        for (i = 0; i < plen; i++) begin
            body[i] = 8'($urandom);
            sum += body[i];
        end
        b = HDR_BYTE;
        if (flaw == FLAW_HEADER) begin
            b = 8'($urandom);
            if (b == HDR_BYTE)
                b = ~b;
        end
        send_byte(b);
        cut = (flaw == FLAW_TRUNCATED) ? $urandom_range(plen - 1) : plen;
        for (i = 0; i < cut; i++)
            send_byte(body[i]);
        if (flaw == FLAW_TRUNCATED)
            return;
        send_byte((flaw == FLAW_CHECKSUM) ? (sum ^ 8'($urandom_range(255, 1))) : sum);
        b = FTR_BYTE;
        if (flaw == FLAW_FOOTER) begin
            b = 8'($urandom);
            if (b == FTR_BYTE)
                b = ~b;
        end
        send_byte(b);
    endtask

    task automatic send_chunk();
        int unsigned roll;
        int unsigned n;
        roll = $urandom_range(99);
        if (roll < 62)
            send_frame(FLAW_NONE);
        else if (roll < 72)
            send_frame(FLAW_CHECKSUM);
        else if (roll < 78)
            send_frame(FLAW_HEADER);
        else if (roll < 84)
            send_frame(FLAW_FOOTER);
        else if (roll < 90)
            send_frame(FLAW_TRUNCATED);
        else begin
            n = $urandom_range(6, 1);
            repeat (n) send_byte(($urandom_range(3) == 0) ? HDR_BYTE : 8'($urandom));
        end
    endtask

    task automatic run_setting(input logic [5:0] plen, input logic [7:0] lim,
                               input int unsigned nbytes);
        int unsigned start;
        settle();
        write_reg(REG_PAYLOAD_LENGTH, {2'b00, plen});
        write_reg(REG_ERROR_LIMIT, lim);
        settings_run++;
        start = sb.bytes_in;
        while (sb.bytes_in - start < nbytes)
            send_chunk();
    endtask

    initial begin
        // payload length 1 throughout: good, bad sum, good, bad header, bad footer
        logic [7:0] dir_short [20];
        // held bytes must be lost on the length write, else AA 22 22 55 would pass
        logic [7:0] dir_part  [2];
        logic [7:0] dir_slide [6];

        dir_short = '{8'hAA, 8'h00, 8'h00, 8'h55,
                      8'hAA, 8'h01, 8'h02, 8'h55,
                      8'hAA, 8'hFF, 8'hFF, 8'h55,
                      8'h00, 8'hAA, 8'h7F, 8'h7F,
                      8'hAA, 8'h80, 8'h80, 8'h54};
        dir_part  = '{8'hAA, 8'h22};
        dir_slide = '{8'h22, 8'h55, 8'hAA, 8'h0F, 8'h0F, 8'h55};

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_reg(REG_PAYLOAD_LENGTH, 8'd0);
        write_reg(REG_ERROR_LIMIT, 8'd0);
        foreach (dir_short[k])
            send_byte(dir_short[k]);
        settle();
        write_reg(REG_ERROR_LIMIT, 8'd255);
        foreach (dir_part[k])
            send_byte(dir_part[k]);
        settle();
        write_reg(REG_PAYLOAD_LENGTH, 8'd1);
        foreach (dir_slide[k])
            send_byte(dir_slide[k]);

        send_idle_pct = 11;
        recv_idle_pct = 78;
        run_setting(6'd3, 8'd2, 10);
        run_setting(6'd32, 8'd255, 1);
        run_setting(6'd0, 8'd1, 6);

        send_idle_pct = 78;
        recv_idle_pct = 11;
        run_setting(6'd63, 8'd16, 1);
        run_setting(6'($urandom_range(12, 1)), 8'($urandom_range(255, 1)), 10);
        run_setting(6'd1, 8'd0, 6);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_setting(6'd5, 8'd255, 10);
        // receiver stalls while whole frames keep coming: input side must back up
        settle();
        write_reg(REG_PAYLOAD_LENGTH, 8'd8);
        settings_run++;
        hold_req = HOLD_CYCLES;
        repeat (2) send_frame(FLAW_NONE);
        run_setting(6'($urandom_range(16, 1)), 8'($urandom_range(255, 1)), 8);

        settle();
        $display("%0d bytes pushed under %0d register settings, %0d cycles",
                 sb.bytes_in, settings_run, cycle_count);
        $display("%0d payload transfers, %0d good frames, %0d checksum failures, %0d mismatches",
                 sb.results_seen, sb.frames_ok, sb.sum_failures, sb.mismatches);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
